/* sv/assert_macros.svh */
// Assertion macros for the light controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled during reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

/* sv/ibtl_pkg.sv */
// Types, constants and register map of the IMU brake/turn light controller.
`default_nettype none

package ibtl_pkg;

    localparam int HISTORY_DEPTH = 128;
    localparam int SAMPLE_BITS   = 16;

    localparam int CFG_BITS  = 16;
    localparam int CMP_W     = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam int POS_W     = $clog2(HISTORY_DEPTH);
    localparam int SUM_W     = SAMPLE_BITS + POS_W + 1;
    localparam int EXC_W     = CMP_W + POS_W + 2;
    localparam int GX_W      = CMP_W + 1;
    localparam int TIME_W    = 32;
    localparam int IN_RAW_W  = 4 * SAMPLE_BITS + TIME_W;
    localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;
    localparam int NUM_REGS  = 7;
    localparam int APB_ADDR_W = $clog2(NUM_REGS * 4);
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BRAKE  = 3'd1,
        MODE_LEFT   = 3'd2,
        MODE_RIGHT  = 3'd3,
        MODE_SLEEP  = 3'd4,
        MODE_TILT   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        REG_UPRIGHT_MIN_X   = 3'd0,
        REG_FORWARD_Y_LIMIT = 3'd1,
        REG_BRAKE_DELTA     = 3'd2,
        REG_TURN_RATE_LIMIT = 3'd3,
        REG_GYRO_X_BIAS     = 3'd4,
        REG_IDLE_TIMEOUT_MS = 3'd5,
        REG_MIN_SHOW_MS     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] upright_min_x;
        logic signed [15:0] forward_y_limit;
        logic [15:0]        brake_delta;
        logic [14:0]        turn_rate_limit;
        logic signed [15:0] gyro_x_bias;
        logic [31:0]        idle_timeout_ms;
        logic [31:0]        min_show_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        upright_min_x:   16'sd3686,
        forward_y_limit: -16'sd1229,
        brake_delta:     16'd835,
        turn_rate_limit: 15'd1280,
        gyro_x_bias:     16'sd71,
        idle_timeout_ms: 32'd15000,
        min_show_ms:     32'd2000
    };

    // Held sample and window sum after one transaction has been applied.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic signed [GX_W-1:0]        gx;
        logic signed [SUM_W-1:0]       sum;
        logic [TIME_W-1:0]             now;
    } snap_t;

endpackage

`default_nettype wire

/* sv/ibtl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ibtl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/ibtl_regs.sv */
// APB configuration register file.
`default_nettype none

module ibtl_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ibtl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ibtl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ibtl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ibtl_pkg::cfg_t                      cfg
);

    ibtl_pkg::cfg_t     cfg_reg;
    ibtl_pkg::cfg_t     cfg_next;
    ibtl_pkg::reg_idx_t idx;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = ibtl_pkg::reg_idx_t'(paddr[ibtl_pkg::APB_ADDR_W-1:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                ibtl_pkg::REG_UPRIGHT_MIN_X:   cfg_next.upright_min_x   = pwdata[15:0];
                ibtl_pkg::REG_FORWARD_Y_LIMIT: cfg_next.forward_y_limit = pwdata[15:0];
                ibtl_pkg::REG_BRAKE_DELTA:     cfg_next.brake_delta     = pwdata[15:0];
                ibtl_pkg::REG_TURN_RATE_LIMIT: cfg_next.turn_rate_limit = pwdata[14:0];
                ibtl_pkg::REG_GYRO_X_BIAS:     cfg_next.gyro_x_bias     = pwdata[15:0];
                ibtl_pkg::REG_IDLE_TIMEOUT_MS: cfg_next.idle_timeout_ms = pwdata;
                ibtl_pkg::REG_MIN_SHOW_MS:     cfg_next.min_show_ms     = pwdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= ibtl_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            ibtl_pkg::REG_UPRIGHT_MIN_X:
                prdata = {{16{cfg_reg.upright_min_x[15]}}, cfg_reg.upright_min_x};
            ibtl_pkg::REG_FORWARD_Y_LIMIT:
                prdata = {{16{cfg_reg.forward_y_limit[15]}}, cfg_reg.forward_y_limit};
            ibtl_pkg::REG_BRAKE_DELTA:     prdata = {16'd0, cfg_reg.brake_delta};
            ibtl_pkg::REG_TURN_RATE_LIMIT: prdata = {17'd0, cfg_reg.turn_rate_limit};
            ibtl_pkg::REG_GYRO_X_BIAS:
                prdata = {{16{cfg_reg.gyro_x_bias[15]}}, cfg_reg.gyro_x_bias};
            ibtl_pkg::REG_IDLE_TIMEOUT_MS: prdata = cfg_reg.idle_timeout_ms;
            ibtl_pkg::REG_MIN_SHOW_MS:     prdata = cfg_reg.min_show_ms;
            default:                       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/ibtl_ring.sv */
// Sample intake: held sample, Z history ring in RAM and its running sum.
`default_nettype none
`include "assert_macros.svh"

module ibtl_ring (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tuser,
    input  logic [ibtl_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic signed [15:0]                 gyro_x_bias,
    input  logic                               c_ready,
    output logic                               b_valid,
    output ibtl_pkg::snap_t                    snap
);

    localparam int SB    = ibtl_pkg::SAMPLE_BITS;
    localparam int DEPTH = ibtl_pkg::HISTORY_DEPTH;
    localparam int PW    = ibtl_pkg::POS_W;
    localparam int GW    = ibtl_pkg::GX_W;
    localparam int SW    = ibtl_pkg::SUM_W;
    localparam int TW    = ibtl_pkg::TIME_W;

    logic signed [SB-1:0] in_ax, in_ay, in_az, in_gr;
    logic [TW-1:0]        in_now;
    logic                 in_upd;
    logic                 accept;
    logic                 move;
    logic                 ram_we;
    logic [SB-1:0]        ram_rdata;
    logic signed [SB-1:0] old_z;

    logic                 vb_reg;
    logic                 upd_b_reg;
    logic                 hit_b_reg;
    logic [PW-1:0]        pos_b_reg;
    logic signed [SB-1:0] ax_b_reg, ay_b_reg, az_b_reg;
    logic signed [GW-1:0] gx_b_reg;
    logic [TW-1:0]        now_b_reg;

    logic [PW-1:0]        pos_reg, pos_next;
    logic [DEPTH-1:0]     valid_reg;
    logic signed [SB-1:0] held_ax_reg, held_ay_reg, held_az_reg;
    logic signed [GW-1:0] held_gx_reg;
    logic signed [SW-1:0] sum_reg;

    assign in_ax  = s_tdata[SB-1:0];
    assign in_ay  = s_tdata[2*SB-1:SB];
    assign in_az  = s_tdata[3*SB-1:2*SB];
    assign in_gr  = s_tdata[4*SB-1:3*SB];
    assign in_now = s_tdata[4*SB+TW-1:4*SB];
    assign in_upd = s_tuser && !(in_ax == '0 && in_ay == '0 && in_az == '0);

    assign s_tready = !vb_reg || c_ready;
    assign accept   = s_tvalid && s_tready;
    assign move     = vb_reg && c_ready;
    assign ram_we   = move && upd_b_reg;
    assign b_valid  = vb_reg;

    assign pos_next = (pos_reg == PW'(DEPTH - 1)) ? '0 : pos_reg + PW'(1);

    ibtl_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_zwin (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (pos_b_reg),
        .wr_data (az_b_reg),
        .rd_en   (s_tready),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    // never-written entries read as zero
    assign old_z = hit_b_reg ? $signed(ram_rdata) : '0;

    always_comb begin
        if (upd_b_reg) begin
            snap.ax  = ax_b_reg;
            snap.ay  = ay_b_reg;
            snap.az  = az_b_reg;
            snap.gx  = gx_b_reg;
            snap.sum = sum_reg + SW'(az_b_reg) - SW'(old_z);
        end else begin
            snap.ax  = held_ax_reg;
            snap.ay  = held_ay_reg;
            snap.az  = held_az_reg;
            snap.gx  = held_gx_reg;
            snap.sum = sum_reg;
        end
        snap.now = now_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg      <= 1'b0;
            pos_reg     <= '0;
            valid_reg   <= '0;
            held_ax_reg <= '0;
            held_ay_reg <= '0;
            held_az_reg <= '0;
            held_gx_reg <= '0;
            sum_reg     <= '0;
        end else begin
            if (s_tready) begin
                vb_reg <= accept;
            end
            if (accept && in_upd) begin
                pos_reg <= pos_next;
            end
            if (ram_we) begin
                valid_reg[pos_b_reg] <= 1'b1;
            end
            if (move) begin
                held_ax_reg <= snap.ax;
                held_ay_reg <= snap.ay;
                held_az_reg <= snap.az;
                held_gx_reg <= snap.gx;
                sum_reg     <= snap.sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            upd_b_reg <= in_upd;
            hit_b_reg <= valid_reg[pos_reg];
            pos_b_reg <= pos_reg;
            ax_b_reg  <= in_ax;
            ay_b_reg  <= in_ay;
            az_b_reg  <= in_az;
            gx_b_reg  <= GW'(in_gr) - GW'(gyro_x_bias);
            now_b_reg <= in_now;
        end
    end

    `ASSERT_PROP(a_pos_only_on_accept, aclk, aresetn,
        !accept |=> $stable(pos_reg), "ring position moved without a transaction")
    `ASSERT_NEVER(a_no_same_entry, aclk, aresetn,
        ram_we && s_tready && (pos_b_reg == pos_reg), "ring read and write hit one entry")
    `ASSERT_PROP(a_b_holds, aclk, aresetn,
        vb_reg && !c_ready |=> vb_reg, "sample stage dropped a held transaction")
    `ASSERT_PROP(a_ready_when_empty, aclk, aresetn,
        !vb_reg |-> s_tready, "intake stalled while empty")

endmodule

`default_nettype wire

/* sv/ibtl_mode.sv */
// Light mode state machine with its compare stage and output register.
`default_nettype none

module ibtl_mode (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ibtl_pkg::cfg_t                      cfg,
    input  logic                                b_valid,
    input  ibtl_pkg::snap_t                     snap,
    output logic                                c_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ibtl_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int CW = ibtl_pkg::CMP_W;
    localparam int EW = ibtl_pkg::EXC_W;
    localparam int GW = ibtl_pkg::GX_W;
    localparam int TW = ibtl_pkg::TIME_W;

    ibtl_pkg::snap_t snap_c_reg;
    logic            vc_reg;
    logic            mvalid_reg;
    logic            out_ready;
    logic            load;

    ibtl_pkg::mode_t mode_reg, mode_next;
    logic [TW-1:0]   last_motion_reg, last_motion_next;
    logic [TW-1:0]   show_start_reg, show_start_next;

    logic signed [EW-1:0] excess, brake_lim;
    logic signed [GW-1:0] turn_lim;
    logic tilt, fwd, brake, left, right, idle_over, show_over;

    assign out_ready = !mvalid_reg || m_tready;
    assign c_ready   = !vc_reg || out_ready;
    assign load      = vc_reg && out_ready;

    assign tilt  = CW'(snap_c_reg.ax) <= CW'(cfg.upright_min_x);
    assign fwd   = CW'(snap_c_reg.ay) < CW'(cfg.forward_y_limit);
    assign excess = EW'(snap_c_reg.az) * EW'(ibtl_pkg::HISTORY_DEPTH) - EW'(snap_c_reg.sum);
    assign brake_lim = $signed(EW'(cfg.brake_delta)) * EW'(ibtl_pkg::HISTORY_DEPTH);
    assign brake = excess > brake_lim;
    assign turn_lim = $signed(GW'(cfg.turn_rate_limit));
    assign left  = snap_c_reg.gx > turn_lim;
    assign right = snap_c_reg.gx < -turn_lim;
    assign idle_over = (snap_c_reg.now - last_motion_reg) > cfg.idle_timeout_ms;
    assign show_over = (snap_c_reg.now - show_start_reg) > cfg.min_show_ms;

    // next state
    always_comb begin
        ibtl_pkg::mode_t m;
        ibtl_pkg::mode_t det;
        logic            major;
        m                = mode_reg;
        det              = ibtl_pkg::MODE_NORMAL;
        major            = 1'b0;
        last_motion_next = last_motion_reg;
        show_start_next  = show_start_reg;
        if (tilt) begin
            m = ibtl_pkg::MODE_TILT;
        end else begin
            if (fwd) begin
                last_motion_next = snap_c_reg.now;
                if (m == ibtl_pkg::MODE_SLEEP) begin
                    m = ibtl_pkg::MODE_NORMAL;
                end
            end else if (m != ibtl_pkg::MODE_SLEEP && idle_over) begin
                m = ibtl_pkg::MODE_SLEEP;
            end
            if (m != ibtl_pkg::MODE_SLEEP) begin
                major = (m == ibtl_pkg::MODE_BRAKE) || (m == ibtl_pkg::MODE_LEFT) ||
                        (m == ibtl_pkg::MODE_RIGHT);
                if (brake) begin
                    det = ibtl_pkg::MODE_BRAKE;
                end else if (left) begin
                    det = ibtl_pkg::MODE_LEFT;
                end else if (right) begin
                    det = ibtl_pkg::MODE_RIGHT;
                end else begin
                    det = ibtl_pkg::MODE_NORMAL;
                end
                if (det != ibtl_pkg::MODE_NORMAL && det != m) begin
                    m               = det;
                    show_start_next = snap_c_reg.now;
                end else if (major && show_over) begin
                    m = ibtl_pkg::MODE_NORMAL;
                end
            end
        end
        mode_next = m;
    end

    // outputs
    always_comb begin
        m_tvalid = mvalid_reg;
        m_tdata  = ibtl_pkg::OUT_DATA_W'(mode_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg          <= 1'b0;
            mvalid_reg      <= 1'b0;
            mode_reg        <= ibtl_pkg::MODE_SLEEP;
            last_motion_reg <= '0;
            show_start_reg  <= '0;
        end else begin
            if (c_ready) begin
                vc_reg <= b_valid;
            end
            if (out_ready) begin
                mvalid_reg <= vc_reg;
            end
            if (load) begin
                mode_reg        <= mode_next;
                last_motion_reg <= last_motion_next;
                show_start_reg  <= show_start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && b_valid) begin
            snap_c_reg <= snap;
        end
    end

endmodule

`default_nettype wire

/* sv/imu_brake_turn_light_fsm.sv */
// Top level of the IMU-driven rear light mode controller.
// Takes one IMU sample transaction per clock while s_tready is high and
// returns one light mode transaction per sample. Each sample with sample_ok
// set and nonzero accel does one read and one write of the 128-entry Z
// history RAM (read at accept, write back as it leaves the sample stage);
// the running window sum replaces any walk over the history. No clearing
// pass runs after reset: per-entry valid bits make unwritten entries read as
// zero. Input back-pressure only appears when the sample stage, the compare
// stage and the output register are all full and the output is stalled.
`default_nettype none

module imu_brake_turn_light_fsm (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [63:48] gyro_x_raw,
    // [95:64] now_ms
    input  logic [ibtl_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] sample_ok
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] light_mode
    output logic [ibtl_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ibtl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ibtl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ibtl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    ibtl_pkg::cfg_t  cfg;
    ibtl_pkg::snap_t snap;
    logic            b_valid;
    logic            c_ready;

    ibtl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ibtl_ring u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .gyro_x_bias (cfg.gyro_x_bias),
        .c_ready     (c_ready),
        .b_valid     (b_valid),
        .snap        (snap)
    );

    ibtl_mode u_mode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .b_valid  (b_valid),
        .snap     (snap),
        .c_ready  (c_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
